/* hw/rtl/acs_pkg.sv */
`timescale 1ns / 1ps
// acs_pkg: shared types and codes for the accumulator CPU step unit.
// No dependencies; imported by acs_mem, acs_alu, accumulator_cpu_step_unit and tb_top.
package acs_pkg;

  localparam int MemBytesDef = 4096;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ADDR = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;
  localparam logic [1:0] STAT_HALT = 2'd3;

  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_IMM   = 4'd15;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] accumulator;
    logic        carry;
    logic [12:0] program_counter;
    logic [3:0]  executed_opcode;
    logic [1:0]  status;
  } res_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_DIV,
    ALU_REM
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [15:0] a;
    logic [11:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [15:0] result;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FETCH1,
    S_FETCH2,
    S_DECODE,
    S_LOAD1,
    S_LOAD2,
    S_STORE2,
    S_ALU
  } state_e;

endpackage

/* hw/rtl/acs_mem.sv */
`timescale 1ns / 1ps
// acs_mem: single-port byte memory with registered read data.
// Depends on acs_pkg for the default depth.
module acs_mem #(
  parameter int MemBytes = acs_pkg::MemBytesDef
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(MemBytes)-1:0] addr_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o
);
  import acs_pkg::*;

  logic [7:0] mem_q [MemBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/acs_alu.sv */
`timescale 1ns / 1ps
// acs_alu: shared iterative unit: registered add, shift-add multiply,
// restoring divide/remainder. Depends on acs_pkg.
module acs_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acs_pkg::alu_cmd_t cmd_i,
  output acs_pkg::alu_rsp_t rsp_o
);
  import acs_pkg::*;

  localparam logic [3:0] MUL_LAST = 4'd11;
  localparam logic [3:0] DIV_LAST = 4'd15;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  alu_op_e     op_q, op_d;
  logic [16:0] sum_q, sum_d;
  logic [27:0] prod_q, prod_d;
  logic [27:0] mcand_q, mcand_d;
  logic [11:0] mplier_q, mplier_d;
  logic [11:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [11:0] dsr_q, dsr_d;

  logic [12:0] trial;
  logic [12:0] diff;
  logic        ge;
  logic        last;

  always_comb begin
    trial = {rem_q, quo_q[15]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
    last  = (op_q == ALU_MUL) ? (cnt_q == MUL_LAST) : (cnt_q == DIV_LAST);

    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    op_d     = op_q;
    sum_d    = sum_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dsr_d    = dsr_q;

    if (cmd_i.start) begin
      op_d     = cmd_i.op;
      cnt_d    = '0;
      sum_d    = {1'b0, cmd_i.a} + {5'b0, cmd_i.b};
      prod_d   = '0;
      mcand_d  = {12'b0, cmd_i.a};
      mplier_d = cmd_i.b;
      rem_d    = '0;
      quo_d    = cmd_i.a;
      dsr_d    = cmd_i.b;
      if (cmd_i.op == ALU_ADD) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 4'd1;
      if (op_q == ALU_MUL) begin
        if (mplier_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d  = {mcand_q[26:0], 1'b0};
        mplier_d = {1'b0, mplier_q[11:1]};
      end else begin
        rem_d = ge ? diff[11:0] : trial[11:0];
        quo_d = {quo_q[14:0], ge};
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_ADD;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    dsr_q    <= dsr_d;
  end

  always_comb begin
    rsp_o.done   = done_q;
    rsp_o.ovf    = 1'b0;
    rsp_o.result = sum_q[15:0];
    case (op_q)
      ALU_ADD: begin
        rsp_o.result = sum_q[15:0];
        rsp_o.ovf    = sum_q[16];
      end
      ALU_MUL: begin
        rsp_o.result = prod_q[15:0];
        rsp_o.ovf    = |prod_q[27:16];
      end
      ALU_DIV: rsp_o.result = quo_q;
      ALU_REM: rsp_o.result = {4'b0, rem_q};
      default: rsp_o.result = sum_q[15:0];
    endcase
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("alu started while busy");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("alu done while still iterating");

endmodule

/* hw/rtl/accumulator_cpu_step_unit.sv */
`timescale 1ns / 1ps
// accumulator_cpu_step_unit: 16-bit accumulator machine, one request per transfer.
// Write, unused or halted: S_IDLE only; read: S_READ; execute: S_FETCH1, S_FETCH2,
// S_DECODE (immediate ends here), then S_LOAD1/2, S_STORE2 or S_ALU (shared iterative ALU).
// One request at a time; busy stays high until the result is issued.
// After reset a clearing pass zeroes every memory byte with busy high.
// Depends on acs_pkg, acs_mem, acs_alu.
module accumulator_cpu_step_unit #(
  parameter int MemBytes = acs_pkg::MemBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  acs_pkg::req_t req_i,
  output logic          done_o,
  output acs_pkg::res_t res_o
);
  import acs_pkg::*;

  localparam int AW = $clog2(MemBytes);
  localparam logic [13:0] MemLim = 14'(MemBytes);
  localparam logic [AW-1:0] ClrLast = AW'(MemBytes - 1);

  state_e      state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [15:0] acc_q, acc_d;
  logic [12:0] pc_q, pc_d;
  logic        carry_q, carry_d;
  logic        halted_q, halted_d;
  logic [15:0] ir_q, ir_d;
  logic [7:0]  hi_q, hi_d;
  logic        done_q, done_d;
  res_t        res_q, res_d;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  alu_cmd_t alu_cmd;
  alu_rsp_t alu_rsp;

  logic        accept;
  logic        finish;
  logic [1:0]  fin_status;
  logic [7:0]  fin_rdata;
  logic [3:0]  fin_opc;
  logic [11:0] arg;
  logic [13:0] arg_nxt;
  logic [13:0] pc_nxt;
  logic        in_ok;
  logic        arg_ok;
  logic        pc_ok;

  acs_mem #(.MemBytes(MemBytes)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  acs_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (alu_cmd),
    .rsp_o (alu_rsp)
  );

  always_comb begin
    busy    = state_q != S_IDLE;
    accept  = start && !busy;
    arg     = ir_q[11:0];
    arg_nxt = 14'(arg) + 14'd1;
    pc_nxt  = 14'(pc_q) + 14'd1;
    in_ok   = 14'(req_i.address) < MemLim;
    arg_ok  = arg_nxt < MemLim;
    pc_ok   = pc_nxt < MemLim;

    state_d  = state_q;
    clr_d    = clr_q;
    acc_d    = acc_q;
    pc_d     = pc_q;
    carry_d  = carry_q;
    halted_d = halted_q;
    ir_d     = ir_q;
    hi_d     = hi_q;
    done_d   = 1'b0;

    mem_we    = 1'b0;
    mem_addr  = AW'(req_i.address);
    mem_wdata = req_i.write_data;

    alu_cmd.start = 1'b0;
    alu_cmd.op    = ALU_ADD;
    alu_cmd.a     = acc_q;
    alu_cmd.b     = arg;

    finish     = 1'b0;
    fin_status = STAT_OK;
    fin_rdata  = '0;
    fin_opc    = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.req_type == REQ_EXEC) begin
          mem_addr = AW'(pc_q);
        end
        if (accept) begin
          if (halted_q) begin
            finish     = 1'b1;
            fin_status = STAT_HALT;
          end else begin
            case (req_i.req_type)
              REQ_WRITE: begin
                finish = 1'b1;
                if (in_ok) begin
                  mem_we = 1'b1;
                end else begin
                  fin_status = STAT_ADDR;
                end
              end
              REQ_READ: begin
                if (in_ok) begin
                  state_d = S_READ;
                end else begin
                  finish     = 1'b1;
                  fin_status = STAT_ADDR;
                end
              end
              REQ_EXEC: begin
                if (pc_ok) begin
                  state_d = S_FETCH1;
                end else begin
                  finish     = 1'b1;
                  fin_status = STAT_ADDR;
                end
              end
              default: finish = 1'b1;
            endcase
          end
        end
      end
      S_READ: begin
        finish    = 1'b1;
        fin_rdata = mem_rdata;
      end
      S_FETCH1: begin
        mem_addr    = AW'(pc_nxt);
        ir_d[15:8]  = mem_rdata;
        state_d     = S_FETCH2;
      end
      S_FETCH2: begin
        ir_d[7:0] = mem_rdata;
        state_d   = S_DECODE;
      end
      S_DECODE: begin
        fin_opc = ir_q[15:12];
        case (ir_q[15:12])
          OP_LOAD: begin
            if (arg_ok) begin
              mem_addr = AW'(arg);
              state_d  = S_LOAD1;
            end else begin
              finish     = 1'b1;
              fin_status = STAT_ADDR;
            end
          end
          OP_STORE: begin
            if (arg_ok) begin
              mem_we    = 1'b1;
              mem_addr  = AW'(arg);
              mem_wdata = acc_q[15:8];
              state_d   = S_STORE2;
            end else begin
              finish     = 1'b1;
              fin_status = STAT_ADDR;
            end
          end
          OP_IMM: begin
            acc_d  = {4'b0, arg};
            pc_d   = pc_q + 13'd2;
            finish = 1'b1;
          end
          OP_ADD: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = ALU_ADD;
            state_d       = S_ALU;
          end
          OP_MUL: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = ALU_MUL;
            state_d       = S_ALU;
          end
          default: begin
            if (arg == '0) begin
              finish     = 1'b1;
              fin_status = STAT_ZERO;
            end else begin
              alu_cmd.start = 1'b1;
              alu_cmd.op    = (ir_q[15:12] == OP_DIV) ? ALU_DIV : ALU_REM;
              state_d       = S_ALU;
            end
          end
        endcase
      end
      S_LOAD1: begin
        fin_opc  = ir_q[15:12];
        mem_addr = AW'(arg_nxt);
        hi_d     = mem_rdata;
        state_d  = S_LOAD2;
      end
      S_LOAD2: begin
        fin_opc = ir_q[15:12];
        acc_d   = {hi_q, mem_rdata};
        pc_d    = pc_q + 13'd2;
        finish  = 1'b1;
      end
      S_STORE2: begin
        fin_opc   = ir_q[15:12];
        mem_we    = 1'b1;
        mem_addr  = AW'(arg_nxt);
        mem_wdata = acc_q[7:0];
        pc_d      = pc_q + 13'd2;
        finish    = 1'b1;
      end
      S_ALU: begin
        fin_opc = ir_q[15:12];
        if (alu_rsp.done) begin
          acc_d   = alu_rsp.result;
          carry_d = carry_q | alu_rsp.ovf;
          pc_d    = pc_q + 13'd2;
          finish  = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      state_d = S_IDLE;
      done_d  = 1'b1;
      if (fin_status == STAT_ADDR || fin_status == STAT_ZERO) begin
        halted_d = 1'b1;
      end
    end

    res_d.read_data       = fin_rdata;
    res_d.accumulator     = acc_d;
    res_d.carry           = carry_d;
    res_d.program_counter = pc_d;
    res_d.executed_opcode = fin_opc;
    res_d.status          = fin_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      acc_q    <= '0;
      pc_q     <= '0;
      carry_q  <= 1'b0;
      halted_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      acc_q    <= acc_d;
      pc_q     <= pc_d;
      carry_q  <= carry_d;
      halted_q <= halted_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d;
    hi_q <= hi_d;
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_halt_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(halted_q) |-> res_o.status == STAT_HALT)
    else $error("item taken while halted did not answer halted");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == STAT_ADDR || res_o.status == STAT_ZERO) |-> halted_q)
    else $error("error transfer without halt");

  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != STAT_OK |->
      acc_q == $past(acc_q) && pc_q == $past(pc_q) && carry_q == $past(carry_q))
    else $error("state changed by failed item");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for accumulator_cpu_step_unit (directed + random requests).
// Depends on acs_pkg and the RTL; a built-in machine model predicts every result.
module tb_top;
  import acs_pkg::*;

  localparam int MEM = MemBytesDef;
  localparam int ITEMS = 1150;
  localparam int GEN = 0;
  localparam int CHK = 1;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [3:0] OP_REM_LO = OP_DIV + 4'd1;
  localparam logic [3:0] OP_REM_HI = OP_IMM - 4'd1;
  localparam logic [11:0] DATA_BASE = 12'hF00;

  typedef struct packed {
    req_t req;
    logic drain;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  res_t res_o;

  accumulator_cpu_step_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // two machine copies: one steers stimulus generation, one predicts results
  logic [7:0]  mem_img [2][MEM];
  logic [15:0] acc_r   [2];
  logic [12:0] pc_r    [2];
  logic        carry_r [2];
  logic        halt_r  [2];

  stim_t request_q[$];
  res_t  due_results[$];
  int    n_issued = 0;
  int    n_accepted = 0;
  int    n_fail = 0;
  int    idle_left = 0;
  int    calm_left = 0;
  logic  drain_next = 1'b0;
  stim_t next_req;
  res_t  want;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("accumulator_cpu_step_unit test failed");
    $finish;
  end

  function automatic void clear_machine(int m);
    for (int i = 0; i < MEM; i++) mem_img[m][i] = '0;
    acc_r[m] = '0;
    pc_r[m] = '0;
    carry_r[m] = 1'b0;
    halt_r[m] = 1'b0;
  endfunction

  function automatic res_t cpu_step(int m, req_t r);
    res_t        o;
    int          pc;
    int          ia;
    logic [15:0] ir;
    logic [3:0]  op;
    logic [11:0] arg;
    logic [16:0] sum;
    logic [27:0] prod;
    logic [15:0] acc;
    o = '0;
    acc = acc_r[m];
    if (halt_r[m]) begin
      o.status = STAT_HALT;
    end else if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
      if (int'(r.address) >= MEM) o.status = STAT_ADDR;
      else if (r.req_type == REQ_WRITE) mem_img[m][r.address] = r.write_data;
      else o.read_data = mem_img[m][r.address];
    end else if (r.req_type == REQ_EXEC) begin
      pc = int'(pc_r[m]);
      if (pc + 1 >= MEM) begin
        o.status = STAT_ADDR;
      end else begin
        ir = {mem_img[m][pc], mem_img[m][pc + 1]};
        op = ir[15:12];
        arg = ir[11:0];
        ia = int'(arg);
        o.executed_opcode = op;
        case (op)
          OP_LOAD: begin
            if (ia + 1 >= MEM) o.status = STAT_ADDR;
            else acc = {mem_img[m][ia], mem_img[m][ia + 1]};
          end
          OP_STORE: begin
            if (ia + 1 >= MEM) begin
              o.status = STAT_ADDR;
            end else begin
              mem_img[m][ia] = acc[15:8];
              mem_img[m][ia + 1] = acc[7:0];
            end
          end
          OP_ADD: begin
            sum = {1'b0, acc} + {5'd0, arg};
            if (sum[16]) carry_r[m] = 1'b1;
            acc = sum[15:0];
          end
          OP_MUL: begin
            prod = 28'(acc) * 28'(arg);
            if (prod[27:16] != '0) carry_r[m] = 1'b1;
            acc = prod[15:0];
          end
          OP_IMM: acc = {4'd0, arg};
          default: begin
            if (arg == '0) o.status = STAT_ZERO;
            else if (op == OP_DIV) acc = acc / arg;
            else acc = acc % arg;
          end
        endcase
        if (o.status == STAT_OK) begin
          acc_r[m] = acc;
          pc_r[m] = 13'(pc + 2);
        end
      end
    end
    if (o.status == STAT_ADDR || o.status == STAT_ZERO) halt_r[m] = 1'b1;
    o.accumulator = acc_r[m];
    o.carry = carry_r[m];
    o.program_counter = pc_r[m];
    return o;
  endfunction

  // true when executing at the current pc of machine m would fault
  function automatic bit exec_faults(int m);
    int          pc;
    logic [3:0]  op;
    logic [11:0] arg;
    pc = int'(pc_r[m]);
    if (pc + 1 >= MEM) return 1'b1;
    op = mem_img[m][pc][7:4];
    arg = {mem_img[m][pc][3:0], mem_img[m][pc + 1]};
    return ((op == OP_LOAD || op == OP_STORE) && int'(arg) + 1 >= MEM) ||
           (op >= OP_DIV && op <= OP_REM_HI && arg == '0);
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, logic [11:0] addr, logic [7:0] data);
    req_t r;
    r.req_type = kind;
    r.address = addr;
    r.write_data = data;
    return r;
  endfunction

  task automatic add_item(req_t r);
    stim_t s;
    void'(cpu_step(GEN, r));
    s.req = r;
    s.drain = drain_next;
    drain_next = 1'b0;
    request_q.push_back(s);
  endtask

  task automatic add_instr(logic [3:0] op, logic [11:0] arg);
    logic [11:0] pc;
    pc = 12'(pc_r[GEN]);
    add_item(mk_req(REQ_WRITE, pc, {op, arg[11:8]}));
    add_item(mk_req(REQ_WRITE, pc + 12'd1, arg[7:0]));
    add_item(mk_req(REQ_EXEC, 12'($urandom), 8'($urandom)));
  endtask

  function automatic logic [11:0] pick_arg(logic [3:0] op);
    logic [11:0] a;
    case ($urandom_range(0, 7))
      0: a = '0;
      1: a = 12'hFFF;
      2: a = 12'($urandom_range(1, 15));
      default: a = 12'($urandom_range(0, 4095));
    endcase
    if (op == OP_LOAD || op == OP_STORE) begin
      if ($urandom_range(0, 9) < 6) a = DATA_BASE + 12'($urandom_range(0, 62));
      if (int'(a) + 1 >= MEM) a = 12'(MEM - 2);
    end
    if (op >= OP_DIV && op <= OP_REM_HI && a == '0) a = 12'd1;
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  task automatic check_result(res_t exp_r, res_t got);
    if (got.read_data !== exp_r.read_data) begin
      $error("read_data: expected %0h, got %0h", exp_r.read_data, got.read_data);
      n_fail++;
    end
    if (got.accumulator !== exp_r.accumulator) begin
      $error("accumulator: expected %0h, got %0h", exp_r.accumulator, got.accumulator);
      n_fail++;
    end
    if (got.carry !== exp_r.carry) begin
      $error("carry: expected %0h, got %0h", exp_r.carry, got.carry);
      n_fail++;
    end
    if (got.program_counter !== exp_r.program_counter) begin
      $error("program_counter: expected %0h, got %0h", exp_r.program_counter,
             got.program_counter);
      n_fail++;
    end
    if (got.executed_opcode !== exp_r.executed_opcode) begin
      $error("executed_opcode: expected %0h, got %0h", exp_r.executed_opcode,
             got.executed_opcode);
      n_fail++;
    end
    if (got.status !== exp_r.status) begin
      $error("status: expected %0h, got %0h", exp_r.status, got.status);
      n_fail++;
    end
  endtask

  // driver: holds each request until its transfer, then idles a random gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || n_accepted == n_issued) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (request_q.size() == 0) begin
        start <= 1'b0;
      end else if (request_q[0].drain && due_results.size() != 0) begin
        start <= 1'b0;
      end else begin
        next_req = request_q.pop_front();
        req_i <= next_req.req;
        start <= 1'b1;
        n_issued++;
        idle_left = pick_gap();
      end
    end
  end

  // monitor: checks results, predicts on every transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding");
          n_fail++;
        end else begin
          want = due_results.pop_front();
          check_result(want, res_o);
        end
      end
      if (start && !busy) begin
        due_results.push_back(cpu_step(CHK, req_i));
        n_accepted++;
      end
    end
  end

  initial begin
    int   n_ignored;
    int   r;
    int   fault_kind;
    req_t q;
    n_ignored = 0;
    clear_machine(GEN);
    clear_machine(CHK);

    // directed
    add_item(mk_req(REQ_READ, 12'h000, 8'h00));
    add_item(mk_req(REQ_READ, 12'hFFF, 8'hFF));
    add_item(mk_req(REQ_WRITE, 12'hFFF, 8'hA5));
    add_item(mk_req(REQ_NONE, 12'hFFF, 8'hFF));
    add_instr(OP_IMM, 12'hFFF);
    add_instr(OP_ADD, 12'hFFF);
    add_instr(OP_STORE, 12'hFFE);
    add_instr(OP_LOAD, 12'hFFE);
    add_instr(OP_DIV, 12'h001);
    add_instr(OP_MUL, 12'hFFF);
    add_instr(OP_REM_HI, 12'hFFF);

    // random: mostly write-instruction-then-execute sequences
    drain_next = 1'b1;
    while (request_q.size() - n_ignored < ITEMS) begin
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 9) < 3) begin
          add_item(mk_req(REQ_WRITE, DATA_BASE + 12'($urandom_range(0, 63)), 8'($urandom)));
        end
        q.write_data = 8'($urandom_range(0, 15));
        add_instr(q.write_data[3:0], pick_arg(q.write_data[3:0]));
      end else if (r < 70) begin
        if ($urandom_range(0, 1) == 0) q.address = DATA_BASE + 12'($urandom_range(0, 63));
        else q.address = 12'($urandom);
        add_item(mk_req(REQ_WRITE, q.address, 8'($urandom)));
      end else if (r < 85) begin
        case ($urandom_range(0, 2))
          0: q.address = DATA_BASE + 12'($urandom_range(0, 63));
          1: q.address = 12'(pc_r[GEN]) - 12'($urandom_range(0, 8));
          default: q.address = 12'($urandom);
        endcase
        add_item(mk_req(REQ_READ, q.address, 8'($urandom)));
      end else if (r < 92) begin
        add_item(mk_req(REQ_NONE, 12'($urandom), 8'($urandom)));
        n_ignored++;
      end else if (!exec_faults(GEN)) begin
        add_item(mk_req(REQ_EXEC, 12'($urandom), 8'($urandom)));
      end
    end

    // one fault per run, then the halted machine
    drain_next = 1'b1;
    fault_kind = $urandom_range(0, 3);
    case (fault_kind)
      0: add_instr(OP_DIV, 12'h000);
      1: add_instr(4'($urandom_range(OP_REM_LO, OP_REM_HI)), 12'h000);
      2: add_instr(OP_LOAD, 12'hFFF);
      default: add_instr(OP_STORE, 12'hFFF);
    endcase
    for (int i = 0; i < 8; i++) begin
      add_item(mk_req(2'($urandom_range(0, 3)), 12'($urandom), 8'($urandom)));
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || n_accepted != n_issued || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("accumulator_cpu_step_unit test passed");
    end else begin
      $display("accumulator_cpu_step_unit test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/acs_pkg.sv
hw/rtl/acs_mem.sv
hw/rtl/acs_alu.sv
hw/rtl/accumulator_cpu_step_unit.sv
bench/tb_top.sv
